>>> src/bpc_pkg.sv
// shared types, constants and codes for the box persistence confirmer
package bpc_pkg;

	localparam int BPC_COORD_BITS    = 10;
	localparam int BPC_MAX_BOXES     = 16;
	localparam int BPC_HISTORY_DEPTH = 8;

	localparam logic [3:0] HIST_LEN_RST = 4'd6;
	localparam logic [3:0] MIN_HITS_RST = 4'd3;
	localparam logic [7:0] IOU_NUM_RST  = 8'd3;
	localparam logic [7:0] IOU_DEN_RST  = 8'd10;

	typedef enum logic [1:0] {
		OP_BOX       = 2'd0,
		OP_FRAME_END = 2'd1,
		OP_CLEAR     = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CFG_HIST_LEN = 2'd0,
		CFG_MIN_HITS = 2'd1,
		CFG_IOU_NUM  = 2'd2,
		CFG_IOU_DEN  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [BPC_COORD_BITS-1:0] x;
		logic [BPC_COORD_BITS-1:0] y;
		logic [BPC_COORD_BITS-1:0] w;
		logic [BPC_COORD_BITS-1:0] h;
	} box_t;

	typedef struct packed {
		logic [1:0]                op;
		logic [BPC_COORD_BITS-1:0] box_x;
		logic [BPC_COORD_BITS-1:0] box_y;
		logic [BPC_COORD_BITS-1:0] box_width;
		logic [BPC_COORD_BITS-1:0] box_height;
	} in_item_t;

	typedef struct packed {
		logic       confirmed;
		logic [3:0] hit_frames;
		logic       stored;
	} out_item_t;

	// tag that travels with each stored-box read through the compare pipe
	typedef struct packed {
		logic valid;
		logic last;
	} scan_tag_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic hit;
	} match_t;

endpackage

>>> src/bpc_box_mem.sv
// box store: one write port, one registered read port
module bpc_box_mem import bpc_pkg::*; #(
	parameter int DEPTH  = BPC_MAX_BOXES * (BPC_HISTORY_DEPTH + 1),
	parameter int ADDR_W = $clog2(BPC_MAX_BOXES * (BPC_HISTORY_DEPTH + 1))
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  box_t              wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output box_t              rd_data
);

	box_t box_mem [DEPTH];
	box_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			box_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= box_mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> src/bpc_iou_pipe.sv
// pipelined exact iou threshold test of the current box against one stored box
module bpc_iou_pipe import bpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  scan_tag_t tag,
	input  box_t      cur_box,
	input  box_t      past_box,
	input  logic [7:0] iou_num,
	input  logic [7:0] iou_den,
	output match_t    result,
	output logic      busy
);

	localparam int C = BPC_COORD_BITS;
	localparam int E = C + 1;
	localparam int A = 2 * C;
	localparam int P = 2 * C + 2;
	localparam int T = P + 8;

	scan_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;

	logic [E-1:0] dx_s2, dy_s2;
	logic [C-1:0] wb_s2, hb_s2;
	logic [P-1:0] inter_s3;
	logic [A-1:0] area_a_s3, area_b_s3;
	logic [P-1:0] inter_s4, uni_s4;
	logic [T-1:0] lhs_s5, rhs_s5;
	logic         zero_s5;

	logic [E-1:0] ax1, ax2, bx1, bx2, ay1, ay2, by1, by2;
	logic [E-1:0] lo_x, hi_x, lo_y, hi_y;

	always_comb begin
		ax1 = E'(cur_box.x);
		bx1 = E'(past_box.x);
		ay1 = E'(cur_box.y);
		by1 = E'(past_box.y);
		ax2 = E'(cur_box.x) + E'(cur_box.w);
		bx2 = E'(past_box.x) + E'(past_box.w);
		ay2 = E'(cur_box.y) + E'(cur_box.h);
		by2 = E'(past_box.y) + E'(past_box.h);
		lo_x = (ax1 > bx1) ? ax1 : bx1;
		hi_x = (ax2 < bx2) ? ax2 : bx2;
		lo_y = (ay1 > by1) ? ay1 : by1;
		hi_y = (ay2 < by2) ? ay2 : by2;
	end

	// valid and last tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	// datapath, at most one multiply level per stage
	always_ff @(posedge clk) begin
		// overlap extent, zero when disjoint
		dx_s2 <= (hi_x > lo_x) ? (hi_x - lo_x) : '0;
		dy_s2 <= (hi_y > lo_y) ? (hi_y - lo_y) : '0;
		wb_s2 <= past_box.w;
		hb_s2 <= past_box.h;

		inter_s3  <= P'(dx_s2) * P'(dy_s2);
		area_a_s3 <= A'(cur_box.w) * A'(cur_box.h);
		area_b_s3 <= A'(wb_s2) * A'(hb_s2);

		inter_s4 <= inter_s3;
		uni_s4   <= P'(area_a_s3) + P'(area_b_s3) - inter_s3;

		lhs_s5  <= T'(inter_s4) * T'(iou_den);
		rhs_s5  <= T'(iou_num) * T'(uni_s4);
		zero_s5 <= (uni_s4 == '0);
	end

	assign result.valid = tag_s5.valid;
	assign result.last  = tag_s5.last;
	assign result.hit   = tag_s5.valid && !zero_s5 && (lhs_s5 > rhs_s5);

	assign busy = tag_s1.valid | tag_s2.valid | tag_s3.valid | tag_s4.valid | tag_s5.valid;

endmodule

>>> src/box_persistence_confirmer.sv
// top level: temporal box confirmation over a ring of past frames
// box transaction: scans compared past frames, one stored box read per cycle; an empty
// frame takes a scan step without a read; compares run through the 5-stage iou pipe
// end-of-frame, clear and unused-op transactions are taken in idle and give no result
// one box at a time, next accept in the cycle its result appears; a held result stalls that
// reset clears frame bookkeeping and config to defaults; box memory is not cleared
module box_persistence_confirmer import bpc_pkg::*; #(
	parameter int MAX_BOXES     = BPC_MAX_BOXES,
	parameter int HISTORY_DEPTH = BPC_HISTORY_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int SLOT_COUNT = HISTORY_DEPTH + 1;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int CNT_W      = $clog2(MAX_BOXES + 1);
	localparam int IDX_W      = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int MEM_DEPTH  = SLOT_COUNT * MAX_BOXES;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int FRM_W      = $clog2(HISTORY_DEPTH + 1);
	localparam int K_W        = $clog2(HISTORY_DEPTH + 2);
	localparam int HIT_X      = (FRM_W > 4) ? FRM_W : 4;

	// config registers
	logic [3:0] hist_len_q, min_hits_q;
	logic [7:0] iou_num_q, iou_den_q;

	// frame ring bookkeeping
	logic [SLOT_W-1:0] fill_slot_q;
	logic [CNT_W-1:0]  fill_count_q;
	logic [CNT_W-1:0]  slot_count_q [SLOT_COUNT];
	logic [FRM_W-1:0]  frames_held_q;

	// per-transaction scan state
	state_t            state_q, state_d;
	box_t              box_q;
	logic [FRM_W-1:0]  past_q;
	logic [K_W-1:0]    k_q;
	logic [IDX_W-1:0]  j_q;
	logic [FRM_W-1:0]  hits_q;
	logic              frame_hit_q;

	// output register
	logic      out_valid_q;
	out_item_t out_data_q;

	logic              in_fire;
	logic [FRM_W-1:0]  lim;
	logic [FRM_W-1:0]  past_now;
	logic [FRM_W:0]    held_inc;
	logic [SLOT_W:0]   slot_sum;
	logic [SLOT_W-1:0] scan_slot;
	logic [SLOT_W-1:0] next_fill;
	logic [CNT_W-1:0]  scan_n;
	logic              scan_done;
	logic              scan_last;
	logic              out_free;
	logic [HIT_X-1:0]  hits_ext;

	scan_tag_t         issue_tag;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	box_t              rd_box;
	match_t            match;
	logic              pipe_busy;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || out_ready;
	assign hits_ext  = HIT_X'(hits_q);

	// history limit: history length saturated to the ring depth
	always_comb begin
		if (int'(hist_len_q) > HISTORY_DEPTH) begin
			lim = FRM_W'(HISTORY_DEPTH);
		end else begin
			lim = FRM_W'(hist_len_q);
		end
		past_now = (frames_held_q < lim) ? frames_held_q : lim;
		held_inc = (FRM_W + 1)'(frames_held_q) + (FRM_W + 1)'(1);
		next_fill = (int'(fill_slot_q) == SLOT_COUNT - 1) ? '0 : fill_slot_q + SLOT_W'(1);
	end

	// slot of the k-th past frame: fill_slot - k around the ring, one compare-subtract
	always_comb begin
		slot_sum = (SLOT_W + 1)'(fill_slot_q) + (SLOT_W + 1)'(SLOT_COUNT) - (SLOT_W + 1)'(k_q);
		if (int'(slot_sum) >= SLOT_COUNT) begin
			scan_slot = SLOT_W'(slot_sum - (SLOT_W + 1)'(SLOT_COUNT));
		end else begin
			scan_slot = SLOT_W'(slot_sum);
		end
		scan_n    = slot_count_q[scan_slot];
		scan_done = (k_q > K_W'(past_q));
		scan_last = ((CNT_W'(j_q) + CNT_W'(1)) == scan_n);
	end

	// next state and memory strobes
	always_comb begin
		state_d   = state_q;
		issue_tag = '0;
		rd_en     = 1'b0;
		rd_addr   = ADDR_W'(scan_slot) * ADDR_W'(MAX_BOXES) + ADDR_W'(j_q);
		wr_en     = 1'b0;
		wr_addr   = ADDR_W'(fill_slot_q) * ADDR_W'(MAX_BOXES)
			+ ADDR_W'(fill_count_q[IDX_W-1:0]);
		case (state_q)
			ST_IDLE: begin
				if (in_fire && op_t'(in_data.op) == OP_BOX) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_DRAIN;
				end else if (scan_n != '0) begin
					// one stored box per cycle from the current past frame
					rd_en           = 1'b1;
					issue_tag.valid = 1'b1;
					issue_tag.last  = scan_last;
				end
			end
			ST_DRAIN: begin
				// wait for every issued compare to leave the pipe
				if (!pipe_busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					wr_en   = (int'(fill_count_q) < MAX_BOXES);
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// config writes, to be made only while idle by contract; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_len_q <= HIST_LEN_RST;
			min_hits_q <= MIN_HITS_RST;
			iou_num_q  <= IOU_NUM_RST;
			iou_den_q  <= IOU_DEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_HIST_LEN: hist_len_q <= cfg_data[3:0];
				CFG_MIN_HITS: min_hits_q <= cfg_data[3:0];
				CFG_IOU_NUM:  iou_num_q  <= cfg_data;
				CFG_IOU_DEN:  iou_den_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame ring, scan counters, hit accumulation and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_slot_q   <= '0;
			fill_count_q  <= '0;
			frames_held_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_count_q[i] <= '0;
			end
			past_q      <= '0;
			k_q         <= '0;
			j_q         <= '0;
			hits_q      <= '0;
			frame_hit_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// the output register empties on its transaction unless a new result lands
			if (out_valid_q && out_ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end

			// a frame hits if any of its boxes matched; counted on its last box
			if (match.valid) begin
				if (match.last) begin
					if (frame_hit_q || match.hit) begin
						hits_q <= hits_q + FRM_W'(1);
					end
					frame_hit_q <= 1'b0;
				end else begin
					frame_hit_q <= frame_hit_q || match.hit;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (op_t'(in_data.op))
							OP_BOX: begin
								past_q      <= past_now;
								k_q         <= K_W'(1);
								j_q         <= '0;
								hits_q      <= '0;
								frame_hit_q <= 1'b0;
							end
							OP_FRAME_END: begin
								// commit the filling frame and open an empty one
								slot_count_q[fill_slot_q] <= fill_count_q;
								fill_slot_q               <= next_fill;
								fill_count_q              <= '0;
								if (held_inc < (FRM_W + 1)'(lim)) begin
									frames_held_q <= FRM_W'(held_inc);
								end else begin
									frames_held_q <= lim;
								end
							end
							OP_CLEAR: begin
								frames_held_q <= '0;
								fill_count_q  <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (!scan_done) begin
						// empty frames are skipped without a memory read
						if (scan_n == '0 || scan_last) begin
							k_q <= k_q + K_W'(1);
							j_q <= '0;
						end else begin
							j_q <= j_q + IDX_W'(1);
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q           <= 1'b1;
						out_data_q.confirmed  <= (hits_ext >= HIT_X'(min_hits_q));
						out_data_q.hit_frames <= hits_ext[3:0];
						out_data_q.stored     <= (int'(fill_count_q) < MAX_BOXES);
						if (int'(fill_count_q) < MAX_BOXES) begin
							fill_count_q <= fill_count_q + CNT_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// box held for the whole transaction
	always_ff @(posedge clk) begin
		if (in_fire) begin
			box_q.x <= in_data.box_x;
			box_q.y <= in_data.box_y;
			box_q.w <= in_data.box_width;
			box_q.h <= in_data.box_height;
		end
	end

	bpc_box_mem #(
		.DEPTH  (MEM_DEPTH),
		.ADDR_W (ADDR_W)
	) u_box_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (box_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_box)
	);

	bpc_iou_pipe u_iou_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag      (issue_tag),
		.cur_box  (box_q),
		.past_box (rd_box),
		.iou_num  (iou_num_q),
		.iou_den  (iou_den_q),
		.result   (match),
		.busy     (pipe_busy)
	);

endmodule
